// ===== hw/rtl/wsq_pkg.sv =====
// Shared types, constants and the microcode program of the write sequencer.
`timescale 1ns / 1ps
`default_nettype none

package wsq_pkg;

  // Program counter width and the width of the configuration register index.
  localparam int unsigned PC_W      = 5;
  localparam int unsigned CFG_IDX_W = 1;

  typedef logic [PC_W-1:0] pc_t;

  // Request codes carried in the mode field.
  typedef enum logic [2:0] {
    MODE_TICK  = 3'd0,
    MODE_FM    = 3'd1,
    MODE_DAC   = 3'd2,
    MODE_PSG   = 3'd3,
    MODE_RESET = 3'd4,
    MODE_MUTE  = 3'd5
  } mode_e;

  // Which strobe a beat fires.
  typedef enum logic [1:0] {
    TGT_FM    = 2'd0,
    TGT_PSG   = 2'd1,
    TGT_RESET = 2'd2
  } target_e;

  // Sequencing action of one control word.
  typedef enum logic [1:0] {
    SEQ_NEXT      = 2'd0,
    SEQ_END       = 2'd1,
    SEQ_BR_STREAM = 2'd2,
    SEQ_HALT      = 2'd3
  } seq_op_e;

  typedef enum logic [1:0] {
    BSEL_REG   = 2'd0,
    BSEL_DATA  = 2'd1,
    BSEL_CONST = 2'd2
  } byte_sel_e;

  typedef enum logic [1:0] {
    HOLD_NONE = 2'd0,
    HOLD_FM   = 2'd1,
    HOLD_PSG  = 2'd2
  } hold_sel_e;

  typedef enum logic [1:0] {
    STR_KEEP  = 2'd0,
    STR_CLEAR = 2'd1,
    STR_SET   = 2'd2
  } stream_op_e;

  typedef enum logic [1:0] {
    EL_KEEP = 2'd0,
    EL_ZERO = 2'd1,
    EL_SAT  = 2'd2
  } elapsed_op_e;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] CFG_FM_BUSY  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PSG_BUSY = 1'b1;
  localparam logic [7:0] FM_BUSY_RST  = 8'd5;
  localparam logic [7:0] PSG_BUSY_RST = 8'd10;
  localparam logic [7:0] ELAPSED_SAT  = 8'hFF;

  // FM chip registers and PSG silence bytes.
  localparam logic [7:0] REG_DAC_DATA  = 8'h2A;
  localparam logic [7:0] REG_DAC_EN    = 8'h2B;
  localparam logic [7:0] REG_KEY_ONOFF = 8'h28;
  localparam logic [7:0] SIL_TONE0     = 8'h9F;
  localparam logic [7:0] SIL_TONE1     = 8'hBF;
  localparam logic [7:0] SIL_TONE2     = 8'hDF;
  localparam logic [7:0] SIL_NOISE     = 8'hFF;

  // Program entry points.
  localparam pc_t PC_FM       = pc_t'(0);
  localparam pc_t PC_DAC      = pc_t'(2);
  localparam pc_t PC_DAC_DATA = pc_t'(4);
  localparam pc_t PC_PSG      = pc_t'(5);
  localparam pc_t PC_RESET    = pc_t'(6);
  localparam pc_t PC_MUTE     = pc_t'(11);

  typedef struct packed {
    seq_op_e     seq_op;
    pc_t         br_target;
    byte_sel_e   byte_sel;
    logic [7:0]  byte_const;
    target_e     target;
    logic        a1_port;
    logic        a0;
    hold_sel_e   hold_sel;
    stream_op_e  stream_op;
    elapsed_op_e elapsed_op;
  } ucode_t;

  // Sequencer to datapath controls.
  typedef struct packed {
    logic   load;
    logic   tick;
    logic   exec;
    ucode_t uw;
  } ctl_t;

  // Datapath to sequencer status.
  typedef struct packed {
    logic out_free;
    logic streaming;
  } dp_stat_t;

  function automatic ucode_t uc(seq_op_e op, byte_sel_e bsel, logic [7:0] bconst,
                                target_e tgt, logic a1p, logic a0, hold_sel_e hsel,
                                stream_op_e sop, elapsed_op_e eop);
    ucode_t w;
    w.seq_op     = op;
    w.br_target  = '0;
    w.byte_sel   = bsel;
    w.byte_const = bconst;
    w.target     = tgt;
    w.a1_port    = a1p;
    w.a0         = a0;
    w.hold_sel   = hsel;
    w.stream_op  = sop;
    w.elapsed_op = eop;
    return w;
  endfunction

  function automatic ucode_t uc_branch(pc_t dest);
    ucode_t w;
    w = uc(SEQ_BR_STREAM, BSEL_CONST, 8'h00, TGT_FM, 1'b0, 1'b0, HOLD_NONE, STR_KEEP,
           EL_KEEP);
    w.br_target = dest;
    return w;
  endfunction

  // The control store. PSG bytes are listed unreversed; the datapath reverses them.
  function automatic ucode_t ucode_at(pc_t pc);
    ucode_t w;
    w = uc(SEQ_HALT, BSEL_CONST, 8'h00, TGT_FM, 1'b0, 1'b0, HOLD_NONE, STR_KEEP, EL_KEEP);
    unique case (pc)
      // FM register write.
      pc_t'(0):  w = uc(SEQ_NEXT, BSEL_REG, 8'h00, TGT_FM, 1'b1, 1'b0, HOLD_FM,
                        STR_CLEAR, EL_ZERO);
      pc_t'(1):  w = uc(SEQ_END, BSEL_DATA, 8'h00, TGT_FM, 1'b1, 1'b1, HOLD_NONE,
                        STR_CLEAR, EL_ZERO);
      // DAC sample: the address strobe is skipped while streaming.
      pc_t'(2):  w = uc_branch(PC_DAC_DATA);
      pc_t'(3):  w = uc(SEQ_NEXT, BSEL_CONST, REG_DAC_DATA, TGT_FM, 1'b0, 1'b0, HOLD_FM,
                        STR_SET, EL_ZERO);
      pc_t'(4):  w = uc(SEQ_END, BSEL_DATA, 8'h00, TGT_FM, 1'b0, 1'b1, HOLD_FM,
                        STR_KEEP, EL_ZERO);
      // PSG write.
      pc_t'(5):  w = uc(SEQ_END, BSEL_DATA, 8'h00, TGT_PSG, 1'b0, 1'b0, HOLD_PSG,
                        STR_CLEAR, EL_ZERO);
      // Chip reset: pulse, then PSG silence.
      pc_t'(6):  w = uc(SEQ_NEXT, BSEL_CONST, 8'h00, TGT_RESET, 1'b0, 1'b0, HOLD_NONE,
                        STR_KEEP, EL_SAT);
      pc_t'(7):  w = uc(SEQ_NEXT, BSEL_CONST, SIL_TONE0, TGT_PSG, 1'b0, 1'b0, HOLD_PSG,
                        STR_CLEAR, EL_ZERO);
      pc_t'(8):  w = uc(SEQ_NEXT, BSEL_CONST, SIL_TONE1, TGT_PSG, 1'b0, 1'b0, HOLD_PSG,
                        STR_CLEAR, EL_ZERO);
      pc_t'(9):  w = uc(SEQ_NEXT, BSEL_CONST, SIL_TONE2, TGT_PSG, 1'b0, 1'b0, HOLD_PSG,
                        STR_CLEAR, EL_ZERO);
      pc_t'(10): w = uc(SEQ_END, BSEL_CONST, SIL_NOISE, TGT_PSG, 1'b0, 1'b0, HOLD_PSG,
                        STR_CLEAR, EL_ZERO);
      // Mute all: PSG silence, six key-offs, DAC disable.
      pc_t'(11): w = uc(SEQ_NEXT, BSEL_CONST, SIL_TONE0, TGT_PSG, 1'b0, 1'b0, HOLD_PSG,
                        STR_CLEAR, EL_ZERO);
      pc_t'(12): w = uc(SEQ_NEXT, BSEL_CONST, SIL_TONE1, TGT_PSG, 1'b0, 1'b0, HOLD_PSG,
                        STR_CLEAR, EL_ZERO);
      pc_t'(13): w = uc(SEQ_NEXT, BSEL_CONST, SIL_TONE2, TGT_PSG, 1'b0, 1'b0, HOLD_PSG,
                        STR_CLEAR, EL_ZERO);
      pc_t'(14): w = uc(SEQ_NEXT, BSEL_CONST, SIL_NOISE, TGT_PSG, 1'b0, 1'b0, HOLD_PSG,
                        STR_CLEAR, EL_ZERO);
      pc_t'(15): w = uc(SEQ_NEXT, BSEL_CONST, REG_KEY_ONOFF, TGT_FM, 1'b0, 1'b0, HOLD_FM,
                        STR_CLEAR, EL_ZERO);
      pc_t'(16): w = uc(SEQ_NEXT, BSEL_CONST, 8'd0, TGT_FM, 1'b0, 1'b1, HOLD_NONE,
                        STR_CLEAR, EL_ZERO);
      pc_t'(17): w = uc(SEQ_NEXT, BSEL_CONST, REG_KEY_ONOFF, TGT_FM, 1'b0, 1'b0, HOLD_FM,
                        STR_CLEAR, EL_ZERO);
      pc_t'(18): w = uc(SEQ_NEXT, BSEL_CONST, 8'd1, TGT_FM, 1'b0, 1'b1, HOLD_NONE,
                        STR_CLEAR, EL_ZERO);
      pc_t'(19): w = uc(SEQ_NEXT, BSEL_CONST, REG_KEY_ONOFF, TGT_FM, 1'b0, 1'b0, HOLD_FM,
                        STR_CLEAR, EL_ZERO);
      pc_t'(20): w = uc(SEQ_NEXT, BSEL_CONST, 8'd2, TGT_FM, 1'b0, 1'b1, HOLD_NONE,
                        STR_CLEAR, EL_ZERO);
      pc_t'(21): w = uc(SEQ_NEXT, BSEL_CONST, REG_KEY_ONOFF, TGT_FM, 1'b0, 1'b0, HOLD_FM,
                        STR_CLEAR, EL_ZERO);
      pc_t'(22): w = uc(SEQ_NEXT, BSEL_CONST, 8'd3, TGT_FM, 1'b0, 1'b1, HOLD_NONE,
                        STR_CLEAR, EL_ZERO);
      pc_t'(23): w = uc(SEQ_NEXT, BSEL_CONST, REG_KEY_ONOFF, TGT_FM, 1'b0, 1'b0, HOLD_FM,
                        STR_CLEAR, EL_ZERO);
      pc_t'(24): w = uc(SEQ_NEXT, BSEL_CONST, 8'd4, TGT_FM, 1'b0, 1'b1, HOLD_NONE,
                        STR_CLEAR, EL_ZERO);
      pc_t'(25): w = uc(SEQ_NEXT, BSEL_CONST, REG_KEY_ONOFF, TGT_FM, 1'b0, 1'b0, HOLD_FM,
                        STR_CLEAR, EL_ZERO);
      pc_t'(26): w = uc(SEQ_NEXT, BSEL_CONST, 8'd5, TGT_FM, 1'b0, 1'b1, HOLD_NONE,
                        STR_CLEAR, EL_ZERO);
      pc_t'(27): w = uc(SEQ_NEXT, BSEL_CONST, REG_DAC_EN, TGT_FM, 1'b0, 1'b0, HOLD_FM,
                        STR_CLEAR, EL_ZERO);
      pc_t'(28): w = uc(SEQ_END, BSEL_CONST, 8'h00, TGT_FM, 1'b0, 1'b1, HOLD_NONE,
                        STR_CLEAR, EL_ZERO);
      default: ;
    endcase
    return w;
  endfunction

  function automatic logic [7:0] reverse8(logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = b[i];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/wsq_req_if.sv =====
// Request channel interface: valid, ready and the request payload.
`timescale 1ns / 1ps
`default_nettype none

interface wsq_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic       port_sel;
  logic [7:0] reg_addr;
  logic [7:0] data_byte;

  modport source (output valid, mode, port_sel, reg_addr, data_byte, input ready);
  modport sink (input valid, mode, port_sel, reg_addr, data_byte, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/wsq_evt_if.sv =====
// Strobe event channel interface: valid, ready and one strobe's fields.
`timescale 1ns / 1ps
`default_nettype none

interface wsq_evt_if;
  logic       valid;
  logic       ready;
  logic [7:0] bus_byte;
  logic [1:0] target;
  logic       a1_level;
  logic       a0_level;
  logic [7:0] hold_off_us;
  logic       stream_on;
  logic       last;

  modport source (output valid, bus_byte, target, a1_level, a0_level, hold_off_us,
                  stream_on, last, input ready);
  modport sink (input valid, bus_byte, target, a1_level, a0_level, hold_off_us,
                stream_on, last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/wsq_sequencer.sv =====
// Microprogram sequencer: request dispatch, step counter and control store lookup.
`timescale 1ns / 1ps
`default_nettype none

module wsq_sequencer import wsq_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  wsq_req_if.sink       req,
  input  wire dp_stat_t stat_i,
  output ctl_t          ctl_o
);

  logic   running_q, running_d;
  pc_t    pc_q, pc_d;
  ucode_t uw;
  logic   accept;

  assign uw        = ucode_at(pc_q);
  assign req.ready = !running_q;
  assign accept    = req.valid && !running_q;

  always_comb begin
    running_d = running_q;
    pc_d      = pc_q;
    ctl_o     = '0;
    ctl_o.uw  = uw;
    if (accept) begin
      ctl_o.load = 1'b1;
      unique case (mode_e'(req.mode))
        MODE_TICK:  ctl_o.tick = 1'b1;
        MODE_FM:    begin pc_d = PC_FM;    running_d = 1'b1; end
        MODE_DAC:   begin pc_d = PC_DAC;   running_d = 1'b1; end
        MODE_PSG:   begin pc_d = PC_PSG;   running_d = 1'b1; end
        MODE_RESET: begin pc_d = PC_RESET; running_d = 1'b1; end
        MODE_MUTE:  begin pc_d = PC_MUTE;  running_d = 1'b1; end
        default: ;
      endcase
    end else if (running_q) begin
      unique case (uw.seq_op)
        SEQ_BR_STREAM: begin
          pc_d = stat_i.streaming ? uw.br_target : pc_q + pc_t'(1);
        end
        SEQ_HALT: begin
          running_d = 1'b0;
        end
        SEQ_NEXT: begin
          if (stat_i.out_free) begin
            ctl_o.exec = 1'b1;
            pc_d       = pc_q + pc_t'(1);
          end
        end
        SEQ_END: begin
          if (stat_i.out_free) begin
            ctl_o.exec = 1'b1;
            running_d  = 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      pc_q      <= '0;
    end else begin
      running_q <= running_d;
      pc_q      <= pc_d;
    end
  end

  // Every program must finish with an end word before it can fall into unused store.
  a_no_halt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q |-> uw.seq_op != SEQ_HALT)
    else $error("sequencer reached an unused control word");

  // A strobe step stalled by the output register must not advance the program.
  a_stall_holds_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q && !stat_i.out_free && (uw.seq_op == SEQ_NEXT || uw.seq_op == SEQ_END)
    |=> $stable(pc_q) && running_q)
    else $error("program advanced while the output beat was stalled");

endmodule

`default_nettype wire

// ===== hw/rtl/wsq_datapath.sv =====
// Datapath: configuration, timing state, operand latch, strobe assembly and output register.
`timescale 1ns / 1ps
`default_nettype none

module wsq_datapath import wsq_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [7:0]           cfg_data_i,
  input  wire logic                 port_sel_i,
  input  wire logic [7:0]           reg_addr_i,
  input  wire logic [7:0]           data_byte_i,
  input  wire ctl_t                 ctl_i,
  output dp_stat_t                  stat_o,
  wsq_evt_if.source                 evt
);

  typedef struct packed {
    logic [7:0] bus_byte;
    target_e    target;
    logic       a1_level;
    logic       a0_level;
    logic [7:0] hold_off_us;
    logic       stream_on;
    logic       last;
  } beat_t;

  logic [7:0] fm_busy_q, psg_busy_q;
  logic       stream_q, stream_d;
  logic [7:0] elapsed_q, elapsed_d;
  logic       out_valid_q, out_valid_d;
  logic       port_q;
  logic [7:0] reg_q, data_q;
  beat_t      beat_q, beat_d;

  logic [7:0] busy;
  logic [7:0] hold;
  logic [7:0] raw_byte;

  always_comb begin
    busy = (ctl_i.uw.hold_sel == HOLD_PSG) ? psg_busy_q : fm_busy_q;
    hold = '0;
    if (ctl_i.uw.hold_sel != HOLD_NONE && elapsed_q < busy) begin
      hold = busy - elapsed_q;
    end
  end

  always_comb begin
    unique case (ctl_i.uw.byte_sel)
      BSEL_REG:   raw_byte = reg_q;
      BSEL_DATA:  raw_byte = data_q;
      BSEL_CONST: raw_byte = ctl_i.uw.byte_const;
      default:    raw_byte = ctl_i.uw.byte_const;
    endcase
  end

  always_comb begin
    stream_d = stream_q;
    if (ctl_i.exec) begin
      unique case (ctl_i.uw.stream_op)
        STR_CLEAR: stream_d = 1'b0;
        STR_SET:   stream_d = 1'b1;
        default:   stream_d = stream_q;
      endcase
    end
  end

  always_comb begin
    elapsed_d = elapsed_q;
    if (ctl_i.tick) begin
      if (elapsed_q != ELAPSED_SAT) begin
        elapsed_d = elapsed_q + 8'd1;
      end
    end else if (ctl_i.exec) begin
      unique case (ctl_i.uw.elapsed_op)
        EL_ZERO: elapsed_d = '0;
        EL_SAT:  elapsed_d = ELAPSED_SAT;
        default: elapsed_d = elapsed_q;
      endcase
    end
  end

  always_comb begin
    beat_d.bus_byte    = (ctl_i.uw.target == TGT_PSG) ? reverse8(raw_byte) : raw_byte;
    beat_d.target      = ctl_i.uw.target;
    beat_d.a1_level    = ctl_i.uw.a1_port & port_q;
    beat_d.a0_level    = ctl_i.uw.a0;
    beat_d.hold_off_us = hold;
    beat_d.stream_on   = stream_d;
    beat_d.last        = (ctl_i.uw.seq_op == SEQ_END);
  end

  assign out_valid_d = ctl_i.exec | (out_valid_q & ~evt.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fm_busy_q   <= FM_BUSY_RST;
      psg_busy_q  <= PSG_BUSY_RST;
      stream_q    <= 1'b0;
      elapsed_q   <= ELAPSED_SAT;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == CFG_FM_BUSY) begin
        fm_busy_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_idx_i == CFG_PSG_BUSY) begin
        psg_busy_q <= cfg_data_i;
      end
      stream_q    <= stream_d;
      elapsed_q   <= elapsed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      port_q <= port_sel_i;
      reg_q  <= reg_addr_i;
      data_q <= data_byte_i;
    end
    if (ctl_i.exec) begin
      beat_q <= beat_d;
    end
  end

  assign stat_o.out_free  = !out_valid_q || evt.ready;
  assign stat_o.streaming = stream_q;

  assign evt.valid       = out_valid_q;
  assign evt.bus_byte    = beat_q.bus_byte;
  assign evt.target      = beat_q.target;
  assign evt.a1_level    = beat_q.a1_level;
  assign evt.a0_level    = beat_q.a0_level;
  assign evt.hold_off_us = beat_q.hold_off_us;
  assign evt.stream_on   = beat_q.stream_on;
  assign evt.last        = beat_q.last;

  // A new beat may only be loaded when the held one is gone or leaves this cycle.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.exec |-> !out_valid_q || evt.ready)
    else $error("output beat overwritten before it was taken");

  // Stream mode can only be reported on FM strobes or the chip reset pulse.
  a_stream_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && beat_q.stream_on |-> beat_q.target == TGT_FM || beat_q.target == TGT_RESET)
    else $error("stream mode reported on a PSG strobe");

  // After every strobe the hold-off timer restarts, except after the reset pulse.
  a_elapsed_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.exec && ctl_i.uw.target != TGT_RESET |=> elapsed_q == '0)
    else $error("elapsed time not cleared after a strobe");

endmodule

`default_nettype wire

// ===== hw/rtl/sound_chip_write_sequencer.sv =====
// Top level of the sound chip write sequencer: microcoded strobe generator.
// The first strobe beat of a request passes the step counter and the output register;
// a DAC sample's program opens with the stream-mode branch word, which issues no beat.
// Beats leave at one beat per cycle while the sink keeps ready high; a new request is
// taken once the running program has issued its last beat to the output register.
// Reset: async active low; busy times 5 and 10 us, stream mode off, elapsed time saturated.
`timescale 1ns / 1ps
`default_nettype none

// The block turns each request beat into an ordered run of strobe beats for the FM and
// PSG chips that share one shift register. A small control store holds one program per
// request type; the sequencer walks it one control word per cycle unless stalled, and
// the datapath builds each strobe from the word, the latched request operands and the
// timing state. The step counter only advances on a strobe word when the output register
// is free or is being emptied in the same cycle, so a stalled sink simply freezes the
// program. New requests are taken only between programs. Tick requests never start a
// program: they bump the saturating microsecond counter in the accept cycle.
// The DAC program begins with a conditional jump that skips the stream address strobe
// when stream mode is already on; the jump word itself issues no beat.
// Configuration writes update the busy times directly; they are expected only while
// no program runs.

module sound_chip_write_sequencer import wsq_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  wsq_req_if.sink                   req,
  wsq_evt_if.source                 evt,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [7:0]           cfg_data_i
);

  // Control word plus load, tick and execute strobes from the sequencer.
  ctl_t     ctl;
  // Output register occupancy and the current stream mode from the datapath.
  dp_stat_t stat;

  wsq_sequencer u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req),
    .stat_i (stat),
    .ctl_o  (ctl)
  );

  // The datapath samples the request operands on the accept cycle; they stay
  // valid on the channel for exactly that edge.
  wsq_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .port_sel_i  (req.port_sel),
    .reg_addr_i  (req.reg_addr),
    .data_byte_i (req.data_byte),
    .ctl_i       (ctl),
    .stat_o      (stat),
    .evt         (evt)
  );

endmodule

`default_nettype wire
